// File: hdl/gnb_pkg.sv
// Shared types and constants for the Gaussian naive Bayes classifier.
package gnb_pkg;

   localparam int VALUE_W     = 32;
   localparam int WEIGHT_W    = 32;
   localparam int LOG_W       = 24;
   localparam int SCORE_W     = 48;
   localparam int CLASS_W     = 2;
   localparam int ATTR_W      = 4;
   localparam int NFEAT_W     = 5;
   localparam int NCLS_W      = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_FEATURE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FEATURES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSES  = 1'b1;

   localparam logic [NFEAT_W-1:0] NUM_FEATURES_RESET = 5'd8;
   localparam logic [NCLS_W-1:0]  NUM_CLASSES_RESET  = 3'd2;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [WEIGHT_W-1:0]       weight_type;
   typedef logic signed [LOG_W-1:0]   log_type;
   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic [CLASS_W-1:0]        class_type;
   typedef logic [ATTR_W-1:0]         attr_type;

   typedef struct packed {
      value_type  mean;
      weight_type weight;
      log_type    log_stdev;
   } entry_type;

   localparam score_type SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam score_type SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

endpackage

// File: hdl/gnb_channels_if.sv
// Valid/ready channel interfaces for classifier requests and responses.
interface gnb_req_if;
   import gnb_pkg::*;
   logic       valid;
   logic       ready;
   logic       operation;
   class_type  class_index;
   attr_type   attr_index;
   value_type  value;
   weight_type weight;
   log_type    log_stdev;
   logic       last;

   modport source (output valid, operation, class_index, attr_index, value, weight,
                   log_stdev, last, input ready);
   modport sink (input valid, operation, class_index, attr_index, value, weight,
                 log_stdev, last, output ready);
endinterface

interface gnb_rsp_if;
   import gnb_pkg::*;
   logic      valid;
   logic      ready;
   class_type predicted_class;
   score_type best_score;

   modport source (output valid, predicted_class, best_score, input ready);
   modport sink (input valid, predicted_class, best_score, output ready);
endinterface

// File: hdl/gaussian_naive_bayes_classifier_unit.sv
// Gaussian naive Bayes classifier: model table, shared multiplier, score argmax.
//
// Usage:
//   req_bus carries one request per handshake. A load request (operation 0)
//   writes the mean, weight and ln(stdev) of one class/attribute entry.
//   A feature request (operation 1) with an attribute below num_features
//   updates every active class score; each class goes through one shared
//   32x32 multiplier (table read, difference, square, two weight products,
//   penalty, score update).
//   A feature with last set then scans the active scores, one per cycle,
//   and, once the rsp_bus output register is free, writes the winner into
//   it, clearing all scores.
//   req_bus.ready is high only while the sequencer is idle. The response
//   register holds a finished result while the receiver stalls and new
//   requests are still accepted; only a second result waits for it.
//   csr_we/csr_index/csr_data write num_features and num_classes; the user must
//   do so only while idle (the block does not check). Reset (synchronous, active
//   high) clears scores and response valid, restores register defaults, keeps table.
module gaussian_naive_bayes_classifier_unit #(
   parameter int MAX_FEATURES = 16,
   parameter int MAX_CLASSES  = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   gnb_req_if.sink                         req_bus,
   gnb_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [gnb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gnb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gnb_pkg::*;

   localparam int DEPTH = MAX_CLASSES * MAX_FEATURES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_CLASSES);
   localparam int NW    = $clog2(MAX_CLASSES + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_DIFF = 4'd2;
   localparam logic [3:0] S_SQ   = 4'd3;
   localparam logic [3:0] S_MHI  = 4'd4;
   localparam logic [3:0] S_MLO  = 4'd5;
   localparam logic [3:0] S_SUM  = 4'd6;
   localparam logic [3:0] S_UPD  = 4'd7;
   localparam logic [3:0] S_ARG  = 4'd8;
   localparam logic [3:0] S_EMIT = 4'd9;

   entry_type mem [DEPTH];
   entry_type rd_ff;

   logic [3:0]         state_ff, state_in;
   logic [NFEAT_W-1:0] num_features_ff;
   logic [NCLS_W-1:0]  num_classes_ff;
   logic [NW-1:0]      ncls;
   logic [CW-1:0]      class_ff, class_in;
   logic               last_ff;
   value_type          x_ff;
   attr_type           attr_ff;
   logic [31:0]        mag_ff;
   logic [63:0]        sq_ff, hi_ff, lo_ff;
   logic [SCORE_W-1:0] pen_ff;
   score_type          scores_ff [MAX_CLASSES];
   class_type          best_ff;
   score_type          best_val_ff;
   logic               rsp_valid_ff;
   class_type          rsp_class_ff;
   score_type          rsp_score_ff;

   logic               req_fire, in_range, last_class, emit_ok;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_out, pen_sum;
   logic [55:0]        pen_raw;
   score_type          cur_score;
   logic signed [SCORE_W+1:0] upd_sum;
   score_type          upd_sat;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign in_range      = (int'(req_bus.attr_index) < int'(num_features_ff)) &&
                          (int'(req_bus.attr_index) < MAX_FEATURES);

   always_comb begin
      if (num_classes_ff == '0) begin
         ncls = NW'(1);
      end else if (int'(num_classes_ff) > MAX_CLASSES) begin
         ncls = NW'(MAX_CLASSES);
      end else begin
         ncls = NW'(num_classes_ff);
      end
   end

   assign last_class = (int'(class_ff) + 1 >= int'(ncls));
   assign emit_ok    = !rsp_valid_ff || rsp_bus.ready;
   assign cur_score  = scores_ff[class_ff];

   // Model table
   assign wr_addr = AW'(req_bus.class_index) * AW'(MAX_FEATURES) + AW'(req_bus.attr_index);
   assign rd_addr = AW'(class_ff) * AW'(MAX_FEATURES) + AW'(attr_ff);

   always_ff @(posedge clock) begin
      if (req_fire && req_bus.operation == OP_LOAD &&
          int'(req_bus.class_index) < MAX_CLASSES &&
          int'(req_bus.attr_index) < MAX_FEATURES) begin
         mem[wr_addr] <= '{mean: req_bus.value, weight: req_bus.weight,
                           log_stdev: req_bus.log_stdev};
      end
      rd_ff <= mem[rd_addr];
   end

   // Shared multiplier
   always_comb begin
      case (state_ff)
         S_SQ: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         S_MHI: begin
            mul_a = sq_ff[63:32];
            mul_b = rd_ff.weight;
         end
         default: begin
            mul_a = sq_ff[31:0];
            mul_b = rd_ff.weight;
         end
      endcase
   end
   assign mul_out = 64'(mul_a) * 64'(mul_b);

   assign diff     = {x_ff[31], x_ff} - {rd_ff.mean[31], rd_ff.mean};
   assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
   assign pen_sum  = hi_ff + {32'd0, lo_ff[63:32]};
   assign pen_raw  = pen_sum[63:8];

   assign upd_sum = (SCORE_W+2)'(cur_score) - (SCORE_W+2)'(rd_ff.log_stdev)
                    - $signed({2'b00, pen_ff});
   always_comb begin
      if (upd_sum > (SCORE_W+2)'(SCORE_MAX)) begin
         upd_sat = SCORE_MAX;
      end else if (upd_sum < (SCORE_W+2)'(SCORE_MIN)) begin
         upd_sat = SCORE_MIN;
      end else begin
         upd_sat = upd_sum[SCORE_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      class_in = class_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_bus.operation == OP_FEATURE) begin
               class_in = '0;
               if (in_range) begin
                  state_in = S_RD;
               end else if (req_bus.last) begin
                  state_in = S_ARG;
               end
            end
         end
         S_RD:   state_in = S_DIFF;
         S_DIFF: state_in = S_SQ;
         S_SQ:   state_in = S_MHI;
         S_MHI:  state_in = S_MLO;
         S_MLO:  state_in = S_SUM;
         S_SUM:  state_in = S_UPD;
         S_UPD: begin
            if (!last_class) begin
               class_in = class_ff + CW'(1);
               state_in = S_RD;
            end else if (last_ff) begin
               class_in = '0;
               state_in = S_ARG;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ARG: begin
            if (last_class) begin
               state_in = S_EMIT;
            end else begin
               class_in = class_ff + CW'(1);
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         class_ff        <= '0;
         num_features_ff <= NUM_FEATURES_RESET;
         num_classes_ff  <= NUM_CLASSES_RESET;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < MAX_CLASSES; i++) begin
            scores_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         class_ff <= class_in;
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_FEATURES: num_features_ff <= csr_data[NFEAT_W-1:0];
               CSR_NUM_CLASSES:  num_classes_ff  <= csr_data[NCLS_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == S_UPD) begin
            scores_ff[class_ff] <= upd_sat;
         end
         if (state_ff == S_EMIT && emit_ok) begin
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < MAX_CLASSES; i++) begin
               scores_ff[i] <= '0;
            end
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff    <= req_bus.value;
         attr_ff <= req_bus.attr_index;
         last_ff <= req_bus.last;
      end
      case (state_ff)
         S_DIFF: mag_ff <= diff_mag[31:0];
         S_SQ:   sq_ff  <= mul_out;
         S_MHI:  hi_ff  <= mul_out;
         S_MLO:  lo_ff  <= mul_out;
         S_SUM: begin
            if (pen_raw > 56'h80_0000_0000_00) begin
               pen_ff <= {1'b1, {(SCORE_W-1){1'b0}}};
            end else begin
               pen_ff <= pen_raw[SCORE_W-1:0];
            end
         end
         S_ARG: begin
            if (class_ff == '0 || cur_score > best_val_ff) begin
               best_ff     <= CLASS_W'(class_ff);
               best_val_ff <= cur_score;
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               rsp_class_ff <= best_ff;
               rsp_score_ff <= best_val_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.predicted_class = rsp_class_ff;
   assign rsp_bus.best_score      = rsp_score_ff;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the Gaussian naive Bayes classifier unit.
module tb_top;
   import gnb_pkg::*;

   localparam int MAX_FEATURES    = 16;
   localparam int MAX_CLASSES     = 4;
   localparam int TABLE_DEPTH     = MAX_FEATURES * MAX_CLASSES;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int SETTLE_CYCLES   = 50;
   localparam int STALL_LIMIT     = 1000;

   typedef struct {
      logic       operation;
      class_type  class_index;
      attr_type   attr_index;
      value_type  value;
      weight_type weight;
      log_type    log_stdev;
      logic       last;
   } request_type;

   typedef struct {
      class_type predicted_class;
      score_type best_score;
   } decision_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   gnb_req_if req_bus();
   gnb_rsp_if rsp_bus();

   gaussian_naive_bayes_classifier_unit #(
      .MAX_FEATURES(MAX_FEATURES),
      .MAX_CLASSES (MAX_CLASSES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #10 clock = ~clock;

   // classifier model state
   value_type          mean_tab[TABLE_DEPTH];
   weight_type         weight_tab[TABLE_DEPTH];
   log_type            log_tab[TABLE_DEPTH];
   score_type          class_score[MAX_CLASSES] = '{default: '0};
   logic [NFEAT_W-1:0] feat_count = NUM_FEATURES_RESET;
   logic [NCLS_W-1:0]  class_count = NUM_CLASSES_RESET;

   request_type  request_queue[$];
   decision_type pending_decisions[$];
   bit           entry_loaded[TABLE_DEPTH];
   request_type  next_req;
   request_type  arrived;
   decision_type want;
   int           queued = 0;
   int           accepted = 0;
   int           mismatches = 0;
   int           send_gap;
   int           stall_left;
   int           dead_cycles;
   bit           steady = 1'b0;

   int phase_features[NUM_PHASES] = '{1, 16, 0, 31, 5, 12, 3, 16};
   int phase_classes[NUM_PHASES]  = '{4, 2, 1, 7, 0, 3, 5, 4};

   function automatic int active_classes();
      if (class_count == 0) return 1;
      if (class_count > MAX_CLASSES) return MAX_CLASSES;
      return int'(class_count);
   endfunction

   task automatic update_scores(input request_type r);
      int                ncls;
      int                best;
      int                a;
      longint            d;
      longint            v;
      longint unsigned   mag;
      logic [95:0]       prod;
      logic [55:0]       pen;
      decision_type      dec;
      ncls = active_classes();
      if (r.operation == OP_LOAD) begin
         a = int'(r.class_index) * MAX_FEATURES + int'(r.attr_index);
         mean_tab[a] = r.value;
         weight_tab[a] = r.weight;
         log_tab[a] = r.log_stdev;
      end else begin
         if (r.attr_index < feat_count) begin
            for (int c = 0; c < ncls; c++) begin
               a = c * MAX_FEATURES + int'(r.attr_index);
               d = longint'(r.value) - longint'(mean_tab[a]);
               mag = (d < 0) ? -d : d;
               prod = 96'(mag * mag) * 96'(weight_tab[a]);
               pen = prod[95:40];
               if (pen > 56'h8000_0000_0000) pen = 56'h8000_0000_0000;
               v = longint'(class_score[c]) - longint'(log_tab[a]) - longint'(pen);
               if (v > longint'(SCORE_MAX)) class_score[c] = SCORE_MAX;
               else if (v < longint'(SCORE_MIN)) class_score[c] = SCORE_MIN;
               else class_score[c] = score_type'(v);
            end
         end
         if (r.last) begin
            best = 0;
            for (int c = 1; c < ncls; c++) begin
               if (class_score[c] > class_score[best]) best = c;
            end
            dec.predicted_class = class_type'(best);
            dec.best_score = class_score[best];
            pending_decisions.push_back(dec);
            foreach (class_score[c]) class_score[c] = '0;
         end
      end
   endtask

   function automatic value_type any_value();
      if ($urandom_range(0, 4) == 0) return value_type'($urandom);
      return value_type'(int'($urandom_range(0, 32'h1F_FFFF)) - 1048576);
   endfunction

   function automatic weight_type any_weight();
      if ($urandom_range(0, 4) == 0) return weight_type'($urandom);
      return weight_type'($urandom_range(0, 32'h400_0000));
   endfunction

   function automatic log_type any_log();
      if ($urandom_range(0, 4) == 0) return log_type'($urandom);
      return log_type'(int'($urandom_range(0, 32'h8_0000)) - 262144);
   endfunction

   task automatic add_load(input class_type c, input attr_type a, input value_type m,
                           input weight_type w, input log_type l, input logic last);
      request_type r;
      r.operation = OP_LOAD;
      r.class_index = c;
      r.attr_index = a;
      r.value = m;
      r.weight = w;
      r.log_stdev = l;
      r.last = last;
      request_queue.push_back(r);
      entry_loaded[int'(c) * MAX_FEATURES + int'(a)] = 1'b1;
      queued++;
   endtask

   // model entries read by this feature are loaded first if still missing
   task automatic add_feature(input attr_type a, input value_type x, input logic last);
      request_type r;
      if (a < feat_count) begin
         for (int c = 0; c < active_classes(); c++) begin
            if (!entry_loaded[c * MAX_FEATURES + int'(a)])
               add_load(class_type'(c), a, any_value(), any_weight(), any_log(),
                        1'($urandom));
         end
      end
      r.operation = OP_FEATURE;
      r.class_index = class_type'($urandom);
      r.attr_index = a;
      r.value = x;
      r.weight = weight_type'($urandom);
      r.log_stdev = log_type'($urandom);
      r.last = last;
      request_queue.push_back(r);
      queued++;
   endtask

   task automatic random_records(input int count);
      int first;
      int span;
      int len;
      first = queued;
      while (queued - first < count) begin
         case ($urandom_range(0, 9))
            0, 1: add_load(class_type'($urandom), attr_type'($urandom), any_value(),
                           any_weight(), any_log(), 1'($urandom));
            2: add_feature(attr_type'($urandom), any_value(), 1'($urandom));
            default: begin
               span = (feat_count > MAX_FEATURES) ? MAX_FEATURES : int'(feat_count);
               len = (span == 0) ? $urandom_range(1, 3) : span;
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 9) == 0)
                     add_load(class_type'($urandom), attr_type'($urandom), any_value(),
                              any_weight(), any_log(), 1'($urandom));
                  add_feature((span == 0) ? attr_type'($urandom) : attr_type'(i),
                              any_value(), i == len - 1);
               end
            end
         endcase
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NUM_FEATURES) feat_count = val[NFEAT_W-1:0];
      else class_count = val[NCLS_W-1:0];
   endtask

   task automatic drain();
      while (accepted != queued || pending_decisions.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.operation <= OP_LOAD;
         req_bus.class_index <= '0;
         req_bus.attr_index <= '0;
         req_bus.value <= '0;
         req_bus.weight <= '0;
         req_bus.log_stdev <= '0;
         req_bus.last <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap--;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            send_gap = $urandom_range(0, 9);
         end else if (request_queue.size() != 0) begin
            next_req = request_queue.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.operation <= next_req.operation;
            req_bus.class_index <= next_req.class_index;
            req_bus.attr_index <= next_req.attr_index;
            req_bus.value <= next_req.value;
            req_bus.weight <= next_req.weight;
            req_bus.log_stdev <= next_req.log_stdev;
            req_bus.last <= next_req.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      if (reset) begin
         dead_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_decisions.size() == 0) begin
               $error("unexpected response: predicted_class %0d best_score %0d",
                      rsp_bus.predicted_class, rsp_bus.best_score);
               mismatches++;
            end else begin
               want = pending_decisions.pop_front();
               if (rsp_bus.predicted_class !== want.predicted_class) begin
                  $error("predicted_class: expected %0d, actual %0d",
                         want.predicted_class, rsp_bus.predicted_class);
                  mismatches++;
               end
               if (rsp_bus.best_score !== want.best_score) begin
                  $error("best_score: expected %0d, actual %0d",
                         want.best_score, rsp_bus.best_score);
                  mismatches++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            arrived.operation = req_bus.operation;
            arrived.class_index = req_bus.class_index;
            arrived.attr_index = req_bus.attr_index;
            arrived.value = req_bus.value;
            arrived.weight = req_bus.weight;
            arrived.log_stdev = req_bus.log_stdev;
            arrived.last = req_bus.last;
            update_scores(arrived);
            accepted++;
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
            dead_cycles = 0;
         end else begin
            dead_cycles++;
            if (dead_cycles >= STALL_LIMIT) begin
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_NUM_FEATURES;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default configuration: 8 attributes, 2 classes
      add_load(2'd0, 4'd0, 32'h0, 32'h0100_0000, 24'h0, 1'b0);
      add_load(2'd1, 4'd0, 32'h0001_0000, 32'h0100_0000, 24'h0, 1'b1);
      add_feature(4'd0, 32'h0, 1'b1);
      add_feature(4'd0, 32'h0001_0000, 1'b1);
      add_feature(4'd0, 32'h0000_8000, 1'b1);   // equal scores, lowest class wins
      // penalty clamp and score saturation
      add_load(2'd0, 4'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'h7F_FFFF, 1'b0);
      add_load(2'd1, 4'd1, 32'h7FFF_FFFF, 32'h0, 24'h80_0000, 1'b0);
      add_feature(4'd1, 32'h8000_0000, 1'b0);
      add_feature(4'd1, 32'h8000_0000, 1'b0);
      add_feature(4'd1, 32'h8000_0000, 1'b1);
      // attribute beyond num_features adds nothing but still classifies
      add_load(2'd0, 4'd15, 32'h8000_0000, 32'hFFFF_FFFF, 24'h80_0000, 1'b0);
      add_load(2'd1, 4'd15, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'h7F_FFFF, 1'b1);
      add_feature(4'd15, 32'h7FFF_FFFF, 1'b1);
      add_feature(4'd0, 32'h7FFF_FFFF, 1'b0);
      add_feature(4'd1, 32'h0, 1'b0);
      add_feature(4'd9, 32'h1234_5678, 1'b1);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_register(CSR_NUM_FEATURES, phase_features[p]);
         write_register(CSR_NUM_CLASSES, phase_classes[p]);
         steady = (p == NUM_PHASES - 1);
         random_records(ITEMS_PER_PHASE);
         drain();
      end

      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: sim.f
hdl/gnb_pkg.sv
hdl/gnb_channels_if.sv
hdl/gaussian_naive_bayes_classifier_unit.sv
sim/tb_top.sv
